// ----- hdl/svpwm_pkg.sv -----
// Shared types and constants for the space vector PWM timing unit.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package svpwm_pkg;

	localparam int DATA_W = 16;
	localparam int MAG_W = 16;
	localparam int SEC_W = 3;

	// sqrt(3)/2 in Q0.15.
	localparam logic signed [DATA_W-1:0] SQRT3_HALF = 16'sd28378;

	localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd4095;

	localparam logic [SEC_W-1:0] SECTOR_1 = 3'd1;
	localparam logic [SEC_W-1:0] SECTOR_2 = 3'd2;
	localparam logic [SEC_W-1:0] SECTOR_3 = 3'd3;
	localparam logic [SEC_W-1:0] SECTOR_4 = 3'd4;
	localparam logic [SEC_W-1:0] SECTOR_5 = 3'd5;
	localparam logic [SEC_W-1:0] SECTOR_6 = 3'd6;

	typedef struct packed {
		logic [SEC_W-1:0] sector;
		logic [MAG_W-1:0] m1;
		logic [MAG_W-1:0] m2;
	} sect_t;

endpackage

`default_nettype wire

// ----- hdl/svpwm_if.sv -----
// Valid/ready channel interfaces for the input vector and the timing result.
// Depends on svpwm_pkg for field widths.
`default_nettype none

interface svpwm_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [svpwm_pkg::DATA_W-1:0]   v_alpha;
	logic signed [svpwm_pkg::DATA_W-1:0]   v_beta;

	modport source (output valid, output v_alpha, output v_beta, input ready);
	modport sink   (input valid, input v_alpha, input v_beta, output ready);
endinterface

interface svpwm_out_if;
	logic                           valid;
	logic                           ready;
	logic [svpwm_pkg::SEC_W-1:0]    sector;
	logic [svpwm_pkg::DATA_W-1:0]   compare_a;
	logic [svpwm_pkg::DATA_W-1:0]   compare_b;
	logic [svpwm_pkg::DATA_W-1:0]   compare_c;
	logic                           overmodulated;

	modport source (output valid, output sector, output compare_a, output compare_b,
		output compare_c, output overmodulated, input ready);
	modport sink   (input valid, input sector, input compare_a, input compare_b,
		input compare_c, input overmodulated, output ready);
endinterface

`default_nettype wire

// ----- hdl/svpwm_sector.sv -----
// Projection and sector decode: forms the two derived projections from the
// registered alpha product and beta, picks the sector and its two magnitudes.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_sector (
	input  wire logic signed [31:0]                  ka,
	input  wire logic signed [svpwm_pkg::DATA_W-1:0] b,
	output svpwm_pkg::sect_t                         sect
);

	logic signed [31:0] hb;
	logic signed [31:0] s2;
	logic signed [31:0] s3;
	logic signed [16:0] p1;
	logic signed [16:0] p2;
	logic signed [16:0] p3;
	logic signed [16:0] n1;
	logic signed [16:0] n2;
	logic signed [16:0] n3;

	assign hb = {{2{b[15]}}, b, 14'b0};
	assign s2 = ka - hb;
	assign s3 = 32'sd0 - hb - ka;

	// Dropping the low 15 bits of a two's complement value floors it.
	assign p1 = {b[15], b};
	assign p2 = s2[31:15];
	assign p3 = s3[31:15];
	assign n1 = 17'sd0 - p1;
	assign n2 = 17'sd0 - p2;
	assign n3 = 17'sd0 - p3;

	always_comb begin
		priority if (p3 > 17'sd0) begin
			priority if (p2 > 17'sd0) begin
				sect.sector = svpwm_pkg::SECTOR_5;
				sect.m1     = p2[15:0];
				sect.m2     = p3[15:0];
			end else if (p1 > 17'sd0) begin
				sect.sector = svpwm_pkg::SECTOR_3;
				sect.m1     = p3[15:0];
				sect.m2     = p1[15:0];
			end else begin
				sect.sector = svpwm_pkg::SECTOR_4;
				sect.m1     = n2[15:0];
				sect.m2     = n1[15:0];
			end
		end else if (p2 > 17'sd0) begin
			priority if (p1 > 17'sd0) begin
				sect.sector = svpwm_pkg::SECTOR_1;
				sect.m1     = p1[15:0];
				sect.m2     = p2[15:0];
			end else begin
				sect.sector = svpwm_pkg::SECTOR_6;
				sect.m1     = n1[15:0];
				sect.m2     = n3[15:0];
			end
		end else begin
			// The zero vector also lands here.
			sect.sector = svpwm_pkg::SECTOR_2;
			sect.m1     = n3[15:0];
			sect.m2     = n2[15:0];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/space_vector_pwm_timing_unit.sv -----
// Seven-segment space vector PWM timing unit, top level.
// An accepted input word is registered in turn by stage 1 to stage 5 and then by the output stage, which drives res.
// Throughput: one word per cycle; each pipeline stage advances unless the next is full.
// Reset clears all valid bits and loads the period register with 4095.
// Depends on svpwm_pkg, svpwm_in_if, svpwm_out_if and svpwm_sector.
`default_nettype none

module space_vector_pwm_timing_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [svpwm_pkg::DATA_W-1:0]  cfg_wr_data,
	svpwm_in_if.sink                           vec,
	svpwm_out_if.source                        res
);

	localparam int T_W = 20;

	logic [svpwm_pkg::DATA_W-1:0] period_q;

	// Valid bits and stage enables.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, res_vld_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;

	// Stage 1: alpha times sqrt(3)/2.
	logic signed [31:0]                  ka_c;
	logic signed [31:0]                  ka_s1;
	logic signed [svpwm_pkg::DATA_W-1:0] b_s1;

	// Stage 2: sector and magnitudes.
	svpwm_pkg::sect_t                    sect_c;
	svpwm_pkg::sect_t                    sect_s2;

	// Stage 3: active times.
	logic [31:0]                         prod1_c;
	logic [31:0]                         prod2_c;
	logic [16:0]                         w1_s3;
	logic [16:0]                         w2_s3;
	logic [svpwm_pkg::SEC_W-1:0]         sec_s3;

	// Stage 4: zero time and start time.
	logic signed [18:0]                  z_c;
	logic signed [17:0]                  t1_s4;
	logic [16:0]                         w1_s4;
	logic [16:0]                         w2_s4;
	logic                                ovm_s4;
	logic [svpwm_pkg::SEC_W-1:0]         sec_s4;

	// Stage 5: segment edges.
	logic signed [T_W-1:0]               t2_c;
	logic signed [T_W-1:0]               t1_s5;
	logic signed [T_W-1:0]               t2_s5;
	logic signed [T_W-1:0]               t3_s5;
	logic                                ovm_s5;
	logic [svpwm_pkg::SEC_W-1:0]         sec_s5;

	// Output stage.
	logic signed [T_W-1:0]               ca_c, cb_c, cc_c;
	logic [svpwm_pkg::SEC_W-1:0]         sector_q;
	logic [svpwm_pkg::DATA_W-1:0]        cmp_a_q, cmp_b_q, cmp_c_q;
	logic                                ovm_q;

	function automatic logic [svpwm_pkg::DATA_W-1:0] clamp_cmp(
		input logic signed [T_W-1:0]        t,
		input logic [svpwm_pkg::DATA_W-1:0] per
	);
		logic signed [T_W-1:0] per_s;
		per_s = $signed({{(T_W-svpwm_pkg::DATA_W){1'b0}}, per});
		if (t < 0)
			return '0;
		else if (t > per_s)
			return per;
		else
			return t[svpwm_pkg::DATA_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			period_q <= svpwm_pkg::PERIOD_RESET;
		else if (cfg_wr_en)
			period_q <= cfg_wr_data;
	end

	assign rdy_out = !res_vld_q || res.ready;
	assign rdy_s5  = !vld_s5 || rdy_out;
	assign rdy_s4  = !vld_s4 || rdy_s5;
	assign rdy_s3  = !vld_s3 || rdy_s4;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign vec.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1    <= vec.valid;
			if (rdy_s2)  vld_s2    <= vld_s1;
			if (rdy_s3)  vld_s3    <= vld_s2;
			if (rdy_s4)  vld_s4    <= vld_s3;
			if (rdy_s5)  vld_s5    <= vld_s4;
			if (rdy_out) res_vld_q <= vld_s5;
		end
	end

	// Stage 1
	assign ka_c = vec.v_alpha * svpwm_pkg::SQRT3_HALF;

	always_ff @(posedge clk) begin
		if (rdy_s1 && vec.valid) begin
			ka_s1 <= ka_c;
			b_s1  <= vec.v_beta;
		end
	end

	// Stage 2
	svpwm_sector u_sector (
		.ka   (ka_s1),
		.b    (b_s1),
		.sect (sect_c)
	);

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1)
			sect_s2 <= sect_c;
	end

	// Stage 3: magnitudes are never negative, so dropping 15 bits is a floor.
	assign prod1_c = period_q * sect_s2.m1;
	assign prod2_c = period_q * sect_s2.m2;

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			w1_s3  <= prod1_c[31:15];
			w2_s3  <= prod2_c[31:15];
			sec_s3 <= sect_s2.sector;
		end
	end

	// Stage 4
	assign z_c = $signed({3'b0, period_q}) - $signed({2'b0, w1_s3})
		- $signed({2'b0, w2_s3});

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			t1_s4  <= z_c[18:1];
			w1_s4  <= w1_s3;
			w2_s4  <= w2_s3;
			ovm_s4 <= z_c[18];
			sec_s4 <= sec_s3;
		end
	end

	// Stage 5
	assign t2_c = T_W'(t1_s4) + $signed({3'b0, w1_s4});

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			t1_s5  <= T_W'(t1_s4);
			t2_s5  <= t2_c;
			t3_s5  <= t2_c + $signed({3'b0, w2_s4});
			ovm_s5 <= ovm_s4;
			sec_s5 <= sec_s4;
		end
	end

	// Output stage: sector mapping, then clamp to 0..period.
	always_comb begin
		unique case (sec_s5)
			svpwm_pkg::SECTOR_1: begin ca_c = t3_s5; cb_c = t2_s5; cc_c = t1_s5; end
			svpwm_pkg::SECTOR_2: begin ca_c = t2_s5; cb_c = t3_s5; cc_c = t1_s5; end
			svpwm_pkg::SECTOR_3: begin ca_c = t1_s5; cb_c = t3_s5; cc_c = t2_s5; end
			svpwm_pkg::SECTOR_4: begin ca_c = t1_s5; cb_c = t2_s5; cc_c = t3_s5; end
			svpwm_pkg::SECTOR_5: begin ca_c = t2_s5; cb_c = t1_s5; cc_c = t3_s5; end
			default:             begin ca_c = t3_s5; cb_c = t1_s5; cc_c = t2_s5; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_out && vld_s5) begin
			sector_q <= sec_s5;
			cmp_a_q  <= clamp_cmp(ca_c, period_q);
			cmp_b_q  <= clamp_cmp(cb_c, period_q);
			cmp_c_q  <= clamp_cmp(cc_c, period_q);
			ovm_q    <= ovm_s5;
		end
	end

	assign res.valid         = res_vld_q;
	assign res.sector        = sector_q;
	assign res.compare_a     = cmp_a_q;
	assign res.compare_b     = cmp_b_q;
	assign res.compare_c     = cmp_c_q;
	assign res.overmodulated = ovm_q;

`ifndef SYNTHESIS
	// A negative zero time puts the start edge below zero, so one compare clamps to 0.
	a_ovm_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.overmodulated |->
		(res.compare_a == '0 || res.compare_b == '0 || res.compare_c == '0))
		else $error("overmodulated word without a compare at zero");

	// The sector decides which phase leads; clamping keeps that order.
	a_order_odd: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |->
		(res.sector == svpwm_pkg::SECTOR_1 && res.compare_a >= res.compare_b
			&& res.compare_b >= res.compare_c) ||
		(res.sector == svpwm_pkg::SECTOR_3 && res.compare_b >= res.compare_c
			&& res.compare_c >= res.compare_a) ||
		(res.sector == svpwm_pkg::SECTOR_5 && res.compare_c >= res.compare_a
			&& res.compare_a >= res.compare_b) ||
		res.sector == svpwm_pkg::SECTOR_2 || res.sector == svpwm_pkg::SECTOR_4 ||
		res.sector == svpwm_pkg::SECTOR_6)
		else $error("phase order does not match odd sector");

	a_order_even: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |->
		(res.sector == svpwm_pkg::SECTOR_2 && res.compare_b >= res.compare_a
			&& res.compare_a >= res.compare_c) ||
		(res.sector == svpwm_pkg::SECTOR_4 && res.compare_c >= res.compare_b
			&& res.compare_b >= res.compare_a) ||
		(res.sector == svpwm_pkg::SECTOR_6 && res.compare_a >= res.compare_c
			&& res.compare_c >= res.compare_b) ||
		res.sector == svpwm_pkg::SECTOR_1 || res.sector == svpwm_pkg::SECTOR_3 ||
		res.sector == svpwm_pkg::SECTOR_5)
		else $error("phase order does not match even sector");
`endif

endmodule

`default_nettype wire
